@@ hdl/sjf_pkg.sv @@
// ----------------------------------------------------------------------------
// sjf_pkg
// shared types and constants of the shortest-job-first scheduler
// ----------------------------------------------------------------------------
package sjf_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [15:0] STOP_TIME_RST = 16'd100;
    localparam logic [15:0] TIME_MAX      = 16'hFFFF;

    // input command codes
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // result kind codes
    localparam logic [2:0] KIND_STORED    = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_RUNNING   = 3'd2;
    localparam logic [2:0] KIND_COMPLETED = 3'd3;
    localparam logic [2:0] KIND_IDLE      = 3'd4;
    localparam logic [2:0] KIND_HALTED    = 3'd5;

    // one stored job
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] need;
    } entry_t;

    // best candidate seen so far, handed from cell to cell
    typedef struct packed {
        logic        found;
        logic [15:0] need;
        logic [7:0]  id;
    } wave_t;

    // store update strobes shared by all cells
    typedef struct packed {
        logic append;
        logic remove;
    } cell_ctl_t;

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  job;
        logic [15:0] start_stamp;
        logic [15:0] end_stamp;
        logic [15:0] now;
    } result_t;

endpackage

@@ hdl/sjf_cell.sv @@
// ----------------------------------------------------------------------------
// sjf_cell
// one slot of the ready store plus one step of the min-run-time search
// ----------------------------------------------------------------------------
module sjf_cell #(
    parameter int QUEUE_DEPTH = sjf_pkg::QUEUE_DEPTH_DEF,
    parameter int INDEX       = 0,
    localparam int IDX_W      = $clog2(QUEUE_DEPTH),
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sjf_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0]   count,
    input  logic [IDX_W-1:0]   remove_idx,
    input  logic [15:0]        now,
    input  sjf_pkg::entry_t    append_entry,
    input  sjf_pkg::entry_t    upper_entry,
    input  sjf_pkg::wave_t     prev_wave,
    input  logic [IDX_W-1:0]   prev_idx,
    output sjf_pkg::entry_t    entry,
    output sjf_pkg::wave_t     wave,
    output logic [IDX_W-1:0]   wave_idx
);

    sjf_pkg::entry_t  entry_reg;
    sjf_pkg::wave_t   wave_reg;
    logic [IDX_W-1:0] wave_idx_reg;
    logic             occupied;
    logic             better;

    assign occupied = CNT_W'(INDEX) < count;
    // strict less-than keeps the earlier stored job on ties
    assign better   = occupied && (entry_reg.arrival <= now)
                      && (!prev_wave.found || (entry_reg.need < prev_wave.need));

    // store: compact on removal, fill at the tail on append
    always_ff @(posedge clk)
    begin
        if (ctl.remove && (IDX_W'(INDEX) >= remove_idx))
        begin
            entry_reg <= upper_entry;
        end
        else if (ctl.append && (CNT_W'(INDEX) == count))
        begin
            entry_reg <= append_entry;
        end
    end

    // search wavefront
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg     <= '0;
            wave_idx_reg <= '0;
        end
        else if (better)
        begin
            wave_reg     <= '{found: 1'b1, need: entry_reg.need, id: entry_reg.id};
            wave_idx_reg <= IDX_W'(INDEX);
        end
        else
        begin
            wave_reg     <= prev_wave;
            wave_idx_reg <= prev_idx;
        end
    end

    assign entry    = entry_reg;
    assign wave     = wave_reg;
    assign wave_idx = wave_idx_reg;

endmodule

@@ hdl/shortest_job_first_scheduler.sv @@
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler
// non-preemptive shortest-job-first scheduler built on a chain of store cells
// ----------------------------------------------------------------------------
//
//  channel  signals                           direction  content
//  -------  --------------------------------  ---------  --------------------------
//  s_*      s_tvalid s_tready s_tdata s_tuser  in         command, job id/arrival/run
//  m_*      m_tvalid m_tready m_tdata m_tuser  out        kind, job, stamps, now
//  cfg_*    cfg_valid cfg_ready cfg_data       in         stop_time register write
//
//  an arrive, a halted tick and a tick with a running job finish in ST_DECIDE
//  a tick with no running job starts a search that walks the cell chain
//    through ST_SEARCH, led by the one-cell-per-cycle search wavefront
//  the next item is taken while a finished result still waits on m_*
//  reset clears time, the active job and the fill count; cell contents are
//    never read beyond the fill count so they need no clearing
//  stop_time resets to 100; cfg_ready is always high
//
module shortest_job_first_scheduler #(
    parameter int QUEUE_DEPTH = sjf_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W      = $clog2(QUEUE_DEPTH),
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // job_id[7:0], arrive_time[23:8], job_run_time[39:24]
    input  logic [0:0]  s_tuser,   // command[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_job[7:0], start_stamp[23:8], end_stamp[39:24],
                                   // now[55:40]
    output logic [2:0]  m_tuser,   // kind[2:0]
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // stop_time
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // accepted item
    logic        cmd_reg;
    logic [7:0]  jid_reg;
    logic [15:0] arr_reg;
    logic [15:0] run_reg;

    // scheduler state
    logic [CNT_W-1:0] count_reg;
    logic             active_valid_reg;
    logic [7:0]       active_job_reg;
    logic [15:0]      active_need_reg;
    logic [15:0]      active_done_reg;
    logic [15:0]      active_start_reg;
    logic [15:0]      time_now_reg;
    logic [15:0]      stop_time_reg;
    logic [IDX_W-1:0] search_cnt_reg;

    // output register and its overflow holding slot
    logic              m_tvalid_reg;
    sjf_pkg::result_t  out_reg;
    sjf_pkg::result_t  hold_reg;

    // cell chain wiring
    sjf_pkg::entry_t  entry_arr [QUEUE_DEPTH];
    sjf_pkg::wave_t   wave_arr  [QUEUE_DEPTH];
    logic [IDX_W-1:0] widx_arr  [QUEUE_DEPTH];
    sjf_pkg::cell_ctl_t cell_ctl;
    sjf_pkg::entry_t    append_entry;
    sjf_pkg::wave_t     tail_wave;
    logic [IDX_W-1:0]   tail_idx;

    // decision logic
    sjf_pkg::result_t res_d;
    logic             fin;
    logic             out_free;
    logic             go_search;
    logic             pick;
    logic             run_active;
    logic             advance;
    logic             store_full;
    logic [15:0]      done_inc;
    logic             active_cmpl;
    logic             pick_cmpl;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = out_reg.kind;
    assign m_tdata   = {out_reg.now, out_reg.end_stamp, out_reg.start_stamp, out_reg.job};

    assign out_free   = !m_tvalid_reg || m_tready;
    assign store_full = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign tail_wave  = wave_arr[QUEUE_DEPTH-1];
    assign tail_idx   = widx_arr[QUEUE_DEPTH-1];
    assign done_inc   = active_done_reg + 16'd1;
    assign active_cmpl = (done_inc >= active_need_reg);
    // a freshly picked job completes at once when it needs a single unit
    assign pick_cmpl  = (tail_wave.need == 16'd1);

    // zero run time is stored as one unit
    assign append_entry = '{id: jid_reg, arrival: arr_reg,
                            need: (run_reg == 16'd0) ? 16'd1 : run_reg};

    assign cell_ctl.append = (state_reg == ST_DECIDE) && (cmd_reg == sjf_pkg::CMD_ARRIVE)
                             && !store_full;
    assign cell_ctl.remove = pick;

    // ------------------------------------------------------------------------
    // cell chain: cell 0 starts the search with no candidate, each cell
    // passes its best to the next one up, the top cell gives the answer
    // ------------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            sjf_pkg::wave_t   prev_wave;
            logic [IDX_W-1:0] prev_idx;
            sjf_pkg::entry_t  upper_entry;

            if (gi == 0)
            begin : g_first
                assign prev_wave = '0;
                assign prev_idx  = '0;
            end
            else
            begin : g_rest
                assign prev_wave = wave_arr[gi-1];
                assign prev_idx  = widx_arr[gi-1];
            end

            // top cell has nothing above; its content is dropped by the count
            if (gi == QUEUE_DEPTH - 1)
            begin : g_top
                assign upper_entry = entry_arr[gi];
            end
            else
            begin : g_inner
                assign upper_entry = entry_arr[gi+1];
            end

            sjf_cell #(
                .QUEUE_DEPTH (QUEUE_DEPTH),
                .INDEX       (gi)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (cell_ctl),
                .count        (count_reg),
                .remove_idx   (tail_idx),
                .now          (time_now_reg),
                .append_entry (append_entry),
                .upper_entry  (upper_entry),
                .prev_wave    (prev_wave),
                .prev_idx     (prev_idx),
                .entry        (entry_arr[gi]),
                .wave         (wave_arr[gi]),
                .wave_idx     (widx_arr[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------------
    // decision for the item in hand
    // ------------------------------------------------------------------------
    always_comb
    begin
        res_d      = '0;
        res_d.now  = time_now_reg;
        fin        = 1'b0;
        go_search  = 1'b0;
        pick       = 1'b0;
        run_active = 1'b0;
        advance    = 1'b0;
        case (state_reg)
            ST_DECIDE:
            begin
                if (cmd_reg == sjf_pkg::CMD_ARRIVE)
                begin
                    fin        = 1'b1;
                    res_d.kind = store_full ? sjf_pkg::KIND_FULL : sjf_pkg::KIND_STORED;
                    res_d.job  = jid_reg;
                end
                else if ((time_now_reg >= stop_time_reg) && !active_valid_reg)
                begin
                    fin        = 1'b1;
                    res_d.kind = sjf_pkg::KIND_HALTED;
                end
                else if (active_valid_reg)
                begin
                    fin        = 1'b1;
                    run_active = 1'b1;
                    advance    = 1'b1;
                    res_d.job  = active_job_reg;
                    if (active_cmpl)
                    begin
                        res_d.kind        = sjf_pkg::KIND_COMPLETED;
                        res_d.start_stamp = active_start_reg;
                        res_d.end_stamp   = time_now_reg;
                    end
                    else
                    begin
                        res_d.kind = sjf_pkg::KIND_RUNNING;
                    end
                end
                else
                begin
                    go_search = 1'b1;
                end
            end
            ST_SEARCH:
            begin
                if (search_cnt_reg == IDX_W'(QUEUE_DEPTH - 1))
                begin
                    fin     = 1'b1;
                    advance = 1'b1;
                    if (tail_wave.found)
                    begin
                        pick      = 1'b1;
                        res_d.job = tail_wave.id;
                        if (pick_cmpl)
                        begin
                            res_d.kind        = sjf_pkg::KIND_COMPLETED;
                            res_d.start_stamp = time_now_reg;
                            res_d.end_stamp   = time_now_reg;
                        end
                        else
                        begin
                            res_d.kind = sjf_pkg::KIND_RUNNING;
                        end
                    end
                    else
                    begin
                        res_d.kind = sjf_pkg::KIND_IDLE;
                    end
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // state, scheduler registers and registered outputs
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            active_valid_reg <= 1'b0;
            active_job_reg   <= '0;
            active_need_reg  <= '0;
            active_done_reg  <= '0;
            active_start_reg <= '0;
            time_now_reg     <= '0;
            stop_time_reg    <= sjf_pkg::STOP_TIME_RST;
            search_cnt_reg   <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                stop_time_reg <= cfg_data;
            end

            // load a finished or parked result, else drop one taken downstream
            if ((fin || (state_reg == ST_EMIT)) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cell_ctl.append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (run_active)
            begin
                active_done_reg <= done_inc;
                if (active_cmpl)
                begin
                    active_valid_reg <= 1'b0;
                end
            end

            if (pick)
            begin
                count_reg        <= count_reg - CNT_W'(1);
                active_valid_reg <= !pick_cmpl;
                active_job_reg   <= tail_wave.id;
                active_need_reg  <= tail_wave.need;
                active_done_reg  <= 16'd1;
                active_start_reg <= time_now_reg;
            end

            // time saturates at its maximum
            if (advance && (time_now_reg != sjf_pkg::TIME_MAX))
            begin
                time_now_reg <= time_now_reg + 16'd1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (go_search)
                    begin
                        search_cnt_reg <= '0;
                        state_reg      <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    search_cnt_reg <= search_cnt_reg + IDX_W'(1);
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // finished item goes straight out, or parks until the output frees
            if (fin)
            begin
                if (out_free)
                begin
                    state_reg <= ST_IDLE;
                end
                else
                begin
                    state_reg <= ST_EMIT;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser[0];
            jid_reg <= s_tdata[7:0];
            arr_reg <= s_tdata[23:8];
            run_reg <= s_tdata[39:24];
        end
        if (fin && out_free)
        begin
            out_reg <= res_d;
        end
        else if (fin)
        begin
            hold_reg <= res_d;
        end
        else if ((state_reg == ST_EMIT) && out_free)
        begin
            out_reg <= hold_reg;
        end
    end

`ifndef SYNTHESIS
    // fill count never passes the store size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("ready count above store size");

    // a parked result only waits behind a result still on the port
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> m_tvalid_reg)
        else $error("parked result with free output");

    // picking a job removes exactly one stored entry
    assert property (@(posedge clk) disable iff (!rst_n)
        pick |=> ($past(count_reg) == count_reg + CNT_W'(1)))
        else $error("pick did not shrink the store by one");

    // a running job has units left to execute
    assert property (@(posedge clk) disable iff (!rst_n)
        active_valid_reg |-> (active_done_reg < active_need_reg))
        else $error("active job past its run time");

    // a search only starts with no job running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> !active_valid_reg)
        else $error("search while a job is active");
`endif

endmodule
